// ----- hdl/tpq_pkg.sv -----
// ---------------------------------------------------------------------------
// tpq_pkg: shared definitions for the two-level priority queue
// Operation and status codes, default sizes and controller commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

  localparam int unsigned LEVEL_DEPTH_DEF = 16;
  localparam int unsigned ID_WIDTH_DEF    = 16;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned FIELD_ID_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 6;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_ENQ_HIGH = 2'd0;
  localparam op_t OP_ENQ_LOW  = 2'd1;
  localparam op_t OP_DEQ      = 2'd2;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/tpq_ctrl.sv -----
// ---------------------------------------------------------------------------
// tpq_ctrl: request sequencer
// Accepts a request, runs the execute state, then strobes the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output logic               done,
  output tpq_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  state_next = S_RESP;
      S_RESP:  state_next = accept ? S_EXEC : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next == S_EXEC);
      done  <= (state == S_EXEC);
    end
  end

  assign cmd.load = accept;
  assign cmd.exec = (state == S_EXEC);

endmodule

`default_nettype wire

// ----- hdl/tpq_datapath.sv -----
// ---------------------------------------------------------------------------
// tpq_datapath: level rings and result registers
// Two ring buffers with head and count, registered reads and result fields.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpq_datapath #(
  parameter int unsigned LEVEL_DEPTH = tpq_pkg::LEVEL_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = tpq_pkg::ID_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tpq_pkg::cmd_t                     cmd,
  input  wire logic [tpq_pkg::OP_W-1:0]          operation,
  input  wire logic [tpq_pkg::FIELD_ID_W-1:0]    customer_id,
  output logic                                   served_valid,
  output logic [tpq_pkg::FIELD_ID_W-1:0]         served_id,
  output logic [tpq_pkg::STATUS_W-1:0]           status,
  output logic [tpq_pkg::COUNT_W-1:0]            waiting_count
);

  localparam int unsigned AW  = $clog2(LEVEL_DEPTH);
  localparam int unsigned CW  = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned FW  = tpq_pkg::FIELD_ID_W;
  localparam int unsigned SAT = (1 << tpq_pkg::COUNT_W) - 1;

  logic [ID_WIDTH-1:0] high_mem [LEVEL_DEPTH];
  logic [ID_WIDTH-1:0] low_mem  [LEVEL_DEPTH];

  tpq_pkg::op_t        op;
  logic [ID_WIDTH-1:0] id;
  logic [AW-1:0]       high_head, high_head_next;
  logic [AW-1:0]       low_head, low_head_next;
  logic [CW-1:0]       high_count, high_count_next;
  logic [CW-1:0]       low_count, low_count_next;
  logic [ID_WIDTH-1:0] high_rd, low_rd;
  logic                sel_low, sel_low_next;
  logic                valid_next;
  tpq_pkg::status_t    status_next;
  logic                high_we, low_we;
  logic [AW-1:0]       high_tail, low_tail;
  logic [CW:0]         high_sum, low_sum;
  logic [31:0]         total;
  logic [ID_WIDTH+FW-1:0] id_ext;
  logic [ID_WIDTH+FW-1:0] out_ext;

  assign id_ext = {{ID_WIDTH{1'b0}}, customer_id};

  assign high_sum  = (CW+1)'(high_head) + (CW+1)'(high_count);
  assign low_sum   = (CW+1)'(low_head) + (CW+1)'(low_count);
  assign high_tail = (high_sum >= (CW+1)'(LEVEL_DEPTH)) ?
                     AW'(high_sum - (CW+1)'(LEVEL_DEPTH)) : AW'(high_sum);
  assign low_tail  = (low_sum >= (CW+1)'(LEVEL_DEPTH)) ?
                     AW'(low_sum - (CW+1)'(LEVEL_DEPTH)) : AW'(low_sum);

  always_comb begin
    high_head_next  = high_head;
    low_head_next   = low_head;
    high_count_next = high_count;
    low_count_next  = low_count;
    sel_low_next    = 1'b0;
    valid_next      = 1'b0;
    status_next     = tpq_pkg::ST_DONE;
    high_we         = 1'b0;
    low_we          = 1'b0;
    case (op)
      tpq_pkg::OP_ENQ_HIGH: begin
        if (high_count == CW'(LEVEL_DEPTH)) begin
          status_next = tpq_pkg::ST_FULL;
        end else begin
          high_we         = 1'b1;
          high_count_next = high_count + CW'(1);
        end
      end
      tpq_pkg::OP_ENQ_LOW: begin
        if (low_count == CW'(LEVEL_DEPTH)) begin
          status_next = tpq_pkg::ST_FULL;
        end else begin
          low_we         = 1'b1;
          low_count_next = low_count + CW'(1);
        end
      end
      tpq_pkg::OP_DEQ: begin
        if (high_count != '0) begin
          valid_next      = 1'b1;
          high_count_next = high_count - CW'(1);
          high_head_next  = (high_head == AW'(LEVEL_DEPTH - 1)) ? '0 : high_head + AW'(1);
        end else if (low_count != '0) begin
          valid_next     = 1'b1;
          sel_low_next   = 1'b1;
          low_count_next = low_count - CW'(1);
          low_head_next  = (low_head == AW'(LEVEL_DEPTH - 1)) ? '0 : low_head + AW'(1);
        end else begin
          status_next = tpq_pkg::ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  assign total = 32'(high_count_next) + 32'(low_count_next);

  always_ff @(posedge clk) begin
    if (cmd.exec && high_we) high_mem[high_tail] <= id;
    if (cmd.exec && low_we)  low_mem[low_tail]   <= id;
    if (cmd.exec) begin
      high_rd <= high_mem[high_head];
      low_rd  <= low_mem[low_head];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation;
      id <= id_ext[ID_WIDTH-1:0];
    end
    if (cmd.exec) begin
      sel_low       <= sel_low_next;
      status        <= status_next;
      waiting_count <= (total > 32'(SAT)) ? tpq_pkg::COUNT_W'(SAT)
                                          : tpq_pkg::COUNT_W'(total);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_head    <= '0;
      low_head     <= '0;
      high_count   <= '0;
      low_count    <= '0;
      served_valid <= 1'b0;
    end else if (cmd.exec) begin
      high_head    <= high_head_next;
      low_head     <= low_head_next;
      high_count   <= high_count_next;
      low_count    <= low_count_next;
      served_valid <= valid_next;
    end
  end

  assign out_ext   = {{FW{1'b0}}, (sel_low ? low_rd : high_rd)};
  assign served_id = served_valid ? out_ext[FW-1:0] : '0;

endmodule

`default_nettype wire

// ----- hdl/two_level_priority_queue.sv -----
// ---------------------------------------------------------------------------
// two_level_priority_queue: strict two-level priority FIFO
// done strobes once an accepted request has passed through the execute state.
// An accepted request blocks a new one during the execute cycle after capture.
// busy is high only in the execute cycle; a new request may come while done.
// Synchronous reset clears heads, counts and served_valid; the ring stores are not cleared.
// The receiver cannot stall: done strobes for one cycle only; result fields hold until the next execute.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_level_priority_queue #(
  parameter int unsigned LEVEL_DEPTH = tpq_pkg::LEVEL_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = tpq_pkg::ID_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [tpq_pkg::OP_W-1:0]       operation,
  input  wire logic [tpq_pkg::FIELD_ID_W-1:0] customer_id,
  output logic                                done,
  output logic                                served_valid,
  output logic [tpq_pkg::FIELD_ID_W-1:0]      served_id,
  output logic [tpq_pkg::STATUS_W-1:0]        status,
  output logic [tpq_pkg::COUNT_W-1:0]         waiting_count
);

  tpq_pkg::cmd_t cmd;

  tpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  tpq_datapath #(
    .LEVEL_DEPTH (LEVEL_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .operation     (operation),
    .customer_id   (customer_id),
    .served_valid  (served_valid),
    .served_id     (served_id),
    .status        (status),
    .waiting_count (waiting_count)
  );

endmodule

`default_nettype wire

// ----- hdl/tpq_checker.sv -----
// ---------------------------------------------------------------------------
// tpq_checker: port-level checks for the priority queue
// Request sequencing and result consistency seen at the top-level ports.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpq_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           done,
  input wire logic                           served_valid,
  input wire logic [tpq_pkg::FIELD_ID_W-1:0] served_id,
  input wire logic [tpq_pkg::STATUS_W-1:0]   status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy && done)
    else $error("execute cycle not followed by result strobe");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !$past(done))
    else $error("result strobe longer than one cycle");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && status == tpq_pkg::ST_EMPTY |-> !served_valid && served_id == '0)
    else $error("empty dequeue returned an identifier");

  a_valid_status: assert property (@(posedge clk) disable iff (rst)
    done && served_valid |-> status == tpq_pkg::ST_DONE)
    else $error("served identifier with error status");

endmodule

bind two_level_priority_queue tpq_checker u_tpq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .served_valid (served_valid),
  .served_id    (served_id),
  .status       (status)
);

`default_nettype wire
